### sv/battery_voltage_to_charge_percent_assert.svh
// Assertion macros shared by the charge estimator modules.
// Depends on nothing; each module that checks its own logic includes this header.
`ifndef BATTERY_VOLTAGE_TO_CHARGE_PERCENT_ASSERT_SVH
`define BATTERY_VOLTAGE_TO_CHARGE_PERCENT_ASSERT_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge outside of reset.
`define BVCP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("bvcp check failed");
// A condition that must be followed by a consequence at the next edge.
`define BVCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bvcp check failed");
`else
`define BVCP_ASSERT(label, clk, rst, prop)
`define BVCP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### sv/bvcp_pkg.sv
// Package for the battery charge estimator: widths, codes, voltage tables and slopes.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package bvcp_pkg;

  // Table geometry
  localparam int TABLE_POINTS = 21;
  localparam int SEG_COUNT    = TABLE_POINTS - 1;
  localparam int IDX_W        = $clog2(SEG_COUNT);
  localparam int NUM_TABLES   = 4;
  localparam int NUM_PACKS    = 5;
  localparam int TAB_W        = $clog2(NUM_TABLES);

  // Field widths
  localparam int VOLT_W  = 15;
  localparam int PCT_W   = 14;
  localparam int STATE_W = 2;
  localparam int PACK_W  = 3;

  // The widest segment of any table is 1600 mV, so an offset inside a segment
  // fits in 11 bits; the steepest slope (25 mV segments) needs 21 bits.
  localparam int OFFSET_W = 11;
  localparam int SLOPE_W  = 21;
  localparam int PROD_W   = SLOPE_W + OFFSET_W;
  localparam int FRAC_W   = 16;

  localparam int FULL_CENTI_INT = 10000;
  localparam int CENTI_STEP_INT = FULL_CENTI_INT / SEG_COUNT;

  typedef logic [VOLT_W-1:0]   volt_t;
  typedef logic [PCT_W-1:0]    pct_t;
  typedef logic [PACK_W-1:0]   pack_t;
  typedef logic [TAB_W-1:0]    tab_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [SLOPE_W-1:0]  slope_t;
  typedef logic [PROD_W-1:0]   prod_t;

  localparam pct_t FULL_CENTI = PCT_W'(FULL_CENTI_INT);
  localparam pct_t CENTI_STEP = PCT_W'(CENTI_STEP_INT);
  localparam prod_t ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

  typedef enum logic [STATE_W-1:0] {
    ST_OK    = 2'd0,
    ST_ERROR = 2'd1,
    ST_DEAD  = 2'd2
  } charge_state_t;

  // Pack type codes; codes above unknown behave as unknown.
  localparam pack_t PACK_1S      = 3'd0;
  localparam pack_t PACK_2S      = 3'd1;
  localparam pack_t PACK_3S      = 3'd2;
  localparam pack_t PACK_4S      = 3'd3;
  localparam pack_t PACK_UNKNOWN = 3'd4;
  localparam pack_t PACK_RESET   = PACK_3S;

  // Unknown packs use the 3S voltage table.
  localparam tab_t TAB_3S = 2'd2;

  // Voltage at each table point in mV, one row per pack type.
  localparam volt_t VOLT_TAB [NUM_TABLES][TABLE_POINTS] = '{
    '{ 3000, 3400, 3500, 3600, 3650, 3675, 3700, 3725, 3750, 3775, 3800,
       3825, 3850, 3875, 3900, 3950, 4000, 4050, 4100, 4150, 4200 },
    '{ 6000, 6800, 7000, 7200, 7300, 7350, 7400, 7450, 7500, 7550, 7600,
       7650, 7700, 7750, 7800, 7900, 8000, 8100, 8200, 8300, 8400 },
    '{ 9000, 10200, 10500, 10800, 10950, 11025, 11100, 11175, 11250, 11325,
       11400, 11475, 11550, 11625, 11700, 11850, 12000, 12150, 12300, 12450,
       12600 },
    '{ 12000, 13600, 14000, 14400, 14600, 14700, 14800, 14900, 15000, 15100,
       15200, 15300, 15400, 15500, 15800, 15800, 16000, 16200, 16400, 16600,
       16800 }
  };

  // Per-segment slope in unsigned Q16: round(step * 65536 / width), half up.
  // The zero-width segment of the 4S table never interpolates and holds 0.
  localparam slope_t SLOPE_TAB [NUM_TABLES][SEG_COUNT] = '{
    '{ 81920, 327680, 327680, 655360, 1310720, 1310720, 1310720, 1310720,
       1310720, 1310720, 1310720, 1310720, 1310720, 1310720, 655360, 655360,
       655360, 655360, 655360, 655360 },
    '{ 40960, 163840, 163840, 327680, 655360, 655360, 655360, 655360,
       655360, 655360, 655360, 655360, 655360, 655360, 327680, 327680,
       327680, 327680, 327680, 327680 },
    '{ 27307, 109227, 109227, 218453, 436907, 436907, 436907, 436907,
       436907, 436907, 436907, 436907, 436907, 436907, 218453, 218453,
       218453, 218453, 218453, 218453 },
    '{ 20480, 81920, 81920, 163840, 327680, 327680, 327680, 327680,
       327680, 327680, 327680, 327680, 327680, 109227, 0, 163840,
       163840, 163840, 163840, 163840 }
  };

  // Thresholds in mV, indexed by pack type code 0 to 4.
  localparam volt_t DEAD_TAB [NUM_PACKS] = '{ 2500, 5000, 7500, 10000, 9000 };
  localparam volt_t ERR_TAB  [NUM_PACKS] = '{ 3000, 6000, 9000, 12000, 11000 };

  // Result of the segment search, carried to the interpolation stage.
  typedef struct packed {
    charge_state_t state;
    logic          full;
    logic          found;
    logic          flat;
    tab_t          tab;
    idx_t          idx;
    offset_t       offset;
  } seg_t;

endpackage

### sv/battery_voltage_to_charge_percent.sv
// Battery pack voltage to state-of-charge estimator, top level.
// Depends on bvcp_pkg, bvcp_seg and bvcp_interp.
//
// Usage:
//   Configuration channel (cfg_valid, cfg_ready, pack_type) sets the pack type:
//   0=1S, 1=2S, 2=3S, 3=4S, 4 and above = unknown (3S table, 9 V / 11 V
//   thresholds). cfg_ready is always high; write only while the block is idle.
//   Input channel (in_valid, in_ready, voltage_mv) takes one voltage in mV per
//   transaction. Output channel (out_valid, out_ready, percent_centi,
//   charge_state) returns one result per input: charge in 0.01 % and a state
//   of 0=ok, 1=error, 2=dead.
//   Throughput: one transaction per cycle while out_ready is high, set by a
//   three-register pipeline (input register, segment search, slope multiply).
//   Reset: rst is synchronous and active high; it empties the pipeline and
//   sets the pack type to 3S.
//   Stall: when out_ready is low the result holds; each stage keeps taking
//   transactions until it is full, so in_ready drops only once all three
//   registers hold pending results.
`timescale 1ns / 1ps

module battery_voltage_to_charge_percent (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bvcp_pkg::PACK_W-1:0]  pack_type,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bvcp_pkg::VOLT_W-1:0]  voltage_mv,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bvcp_pkg::PCT_W-1:0]   percent_centi,
  output logic [bvcp_pkg::STATE_W-1:0] charge_state
);

  bvcp_pkg::pack_t pack_sel;
  logic            vin_valid;
  bvcp_pkg::volt_t voltage;
  logic            seg_up_ready;
  logic            seg_valid;
  bvcp_pkg::seg_t  seg;
  logic            seg_ready;

  // Pack type register, written on every configuration transaction.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_sel <= bvcp_pkg::PACK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pack_sel <= pack_type;
    end
  end

  // Input register.
  assign in_ready = !vin_valid || seg_up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vin_valid <= 1'b0;
    end else if (in_ready) begin
      vin_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      voltage <= voltage_mv;
    end
  end

  // Segment search stage.
  bvcp_seg u_seg (
    .clk        (clk),
    .rst        (rst),
    .pack_sel   (pack_sel),
    .up_valid   (vin_valid),
    .voltage    (voltage),
    .up_ready   (seg_up_ready),
    .seg_valid  (seg_valid),
    .seg        (seg),
    .down_ready (seg_ready)
  );

  // Interpolation stage and result register.
  bvcp_interp u_interp (
    .clk           (clk),
    .rst           (rst),
    .seg_valid     (seg_valid),
    .seg           (seg),
    .seg_ready     (seg_ready),
    .out_valid     (out_valid),
    .percent_centi (percent_centi),
    .charge_state  (charge_state),
    .out_ready     (out_ready)
  );

endmodule

### sv/bvcp_seg.sv
// Segment search stage: thresholds, full check and first matching table segment.
// Depends on bvcp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "battery_voltage_to_charge_percent_assert.svh"

module bvcp_seg (
  input  logic                  clk,
  input  logic                  rst,
  input  bvcp_pkg::pack_t       pack_sel,
  input  logic                  up_valid,
  input  bvcp_pkg::volt_t       voltage,
  output logic                  up_ready,
  output logic                  seg_valid,
  output bvcp_pkg::seg_t        seg,
  input  logic                  down_ready
);

  bvcp_pkg::pack_t                    sel;
  bvcp_pkg::tab_t                     tab;
  logic [bvcp_pkg::SEG_COUNT-1:0]     hit;
  bvcp_pkg::idx_t                     idx_sel;
  bvcp_pkg::volt_t                    lo_sel;
  logic                               flat_sel;
  bvcp_pkg::seg_t                     seg_next;
  logic                               load;

  // Pack type and voltage table selection.
  always_comb begin
    sel = (pack_sel > bvcp_pkg::PACK_UNKNOWN) ? bvcp_pkg::PACK_UNKNOWN : pack_sel;
    tab = (sel == bvcp_pkg::PACK_UNKNOWN) ? bvcp_pkg::TAB_3S : sel[bvcp_pkg::TAB_W-1:0];
  end

  // Compare against every segment in parallel and keep the lowest one that holds
  // the voltage.
  always_comb begin
    idx_sel  = '0;
    lo_sel   = '0;
    flat_sel = 1'b0;
    for (int k = 0; k < bvcp_pkg::SEG_COUNT; k++) begin
      hit[k] = (voltage >= bvcp_pkg::VOLT_TAB[tab][k]) &&
               (voltage <= bvcp_pkg::VOLT_TAB[tab][k+1]);
    end
    for (int k = bvcp_pkg::SEG_COUNT - 1; k >= 0; k--) begin
      if (hit[k]) begin
        idx_sel  = bvcp_pkg::IDX_W'(k);
        lo_sel   = bvcp_pkg::VOLT_TAB[tab][k];
        flat_sel = (bvcp_pkg::VOLT_TAB[tab][k+1] <= bvcp_pkg::VOLT_TAB[tab][k]);
      end
    end
  end

  // Charge state and segment record for the next stage.
  always_comb begin
    if (voltage < bvcp_pkg::DEAD_TAB[sel]) begin
      seg_next.state = bvcp_pkg::ST_DEAD;
    end else if (voltage < bvcp_pkg::ERR_TAB[sel]) begin
      seg_next.state = bvcp_pkg::ST_ERROR;
    end else begin
      seg_next.state = bvcp_pkg::ST_OK;
    end
    seg_next.full   = (seg_next.state == bvcp_pkg::ST_OK) &&
                      (voltage >= bvcp_pkg::VOLT_TAB[tab][bvcp_pkg::TABLE_POINTS-1]);
    seg_next.found  = (seg_next.state == bvcp_pkg::ST_OK) && !seg_next.full && (|hit);
    seg_next.flat   = flat_sel;
    seg_next.tab    = tab;
    seg_next.idx    = idx_sel;
    seg_next.offset = bvcp_pkg::OFFSET_W'(voltage - lo_sel);
  end

  // The stage takes a new transaction when it is empty or its contents move on.
  assign load     = !seg_valid || down_ready;
  assign up_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (load) begin
      seg_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      seg <= seg_next;
    end
  end

  // A stalled segment record must not change under the next stage.
  `BVCP_ASSERT_NEXT(a_seg_hold, clk, rst, seg_valid && !down_ready, seg_valid && $stable(seg))
  // Dead and error states never carry a full or interpolation result.
  `BVCP_ASSERT(a_seg_state, clk, rst,
               (seg_valid && seg.state != bvcp_pkg::ST_OK) |-> (!seg.found && !seg.full))
  // A found segment always indexes inside the table.
  `BVCP_ASSERT(a_seg_idx, clk, rst,
               (seg_valid && seg.found) |-> (seg.idx < bvcp_pkg::IDX_W'(bvcp_pkg::SEG_COUNT)))

endmodule

### sv/bvcp_interp.sv
// Interpolation stage: slope multiply, rounding, saturation and the result register.
// Depends on bvcp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "battery_voltage_to_charge_percent_assert.svh"

module bvcp_interp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       seg_valid,
  input  bvcp_pkg::seg_t             seg,
  output logic                       seg_ready,
  output logic                       out_valid,
  output bvcp_pkg::pct_t             percent_centi,
  output logic [bvcp_pkg::STATE_W-1:0] charge_state,
  input  logic                       out_ready
);

  localparam int ADD_W = bvcp_pkg::PROD_W + 1 - bvcp_pkg::FRAC_W;
  localparam int SUM_W = ADD_W + 1;

  bvcp_pkg::pct_t              base;
  bvcp_pkg::slope_t            slope;
  bvcp_pkg::prod_t             prod;
  logic [bvcp_pkg::PROD_W:0]   rounded;
  logic [ADD_W-1:0]            add;
  logic [SUM_W-1:0]            sum;
  bvcp_pkg::pct_t              interp;
  bvcp_pkg::pct_t              pct_next;
  logic                        load;

  // Segment base percentage and slope-times-offset with round half up.
  always_comb begin
    base    = bvcp_pkg::PCT_W'(seg.idx) * bvcp_pkg::CENTI_STEP;
    slope   = bvcp_pkg::SLOPE_TAB[seg.tab][seg.idx];
    prod    = bvcp_pkg::PROD_W'(slope) * bvcp_pkg::PROD_W'(seg.offset);
    rounded = {1'b0, prod} + {1'b0, bvcp_pkg::ROUND_HALF};
    add     = rounded[bvcp_pkg::PROD_W:bvcp_pkg::FRAC_W];
    sum     = SUM_W'(base) + SUM_W'(add);
    interp  = (sum > SUM_W'(bvcp_pkg::FULL_CENTI)) ? bvcp_pkg::FULL_CENTI
                                                  : bvcp_pkg::PCT_W'(sum);
  end

  // Final percentage by case: full, flat segment, interpolated, or zero.
  always_comb begin
    if (seg.full) begin
      pct_next = bvcp_pkg::FULL_CENTI;
    end else if (seg.found) begin
      pct_next = seg.flat ? base : interp;
    end else begin
      pct_next = '0;
    end
  end

  // The result register frees up when empty or when the receiver takes it.
  assign load      = !out_valid || out_ready;
  assign seg_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && seg_valid) begin
      percent_centi <= pct_next;
      charge_state  <= seg.state;
    end
  end

  // The estimate never exceeds a full charge.
  `BVCP_ASSERT(a_out_range, clk, rst, out_valid |-> (percent_centi <= bvcp_pkg::FULL_CENTI))
  // Dead and error results always report zero charge.
  `BVCP_ASSERT(a_out_zero, clk, rst,
               (out_valid && charge_state != bvcp_pkg::ST_OK) |-> (percent_centi == '0))

endmodule

### verif/battery_voltage_to_charge_percent_test.sv
// Self-checking testbench for the battery voltage to charge estimator.
// Depends on bvcp_pkg and battery_voltage_to_charge_percent; it reads no files.
// Checks every result against a built-in piecewise linear charge predictor.
`timescale 1ns / 1ps

module battery_voltage_to_charge_percent_test;

  typedef logic [bvcp_pkg::VOLT_W-1:0]  volt_t;
  typedef logic [bvcp_pkg::PCT_W-1:0]   pct_t;
  typedef logic [bvcp_pkg::PACK_W-1:0]  pack_t;
  typedef bvcp_pkg::charge_state_t      charge_state_t;

  // Pack codes above unknown have no name in the package; they act as unknown.
  localparam pack_t PACK_SPARE_5 = 3'd5;
  localparam pack_t PACK_SPARE_6 = 3'd6;
  localparam pack_t PACK_SPARE_7 = 3'd7;

  localparam int POINTS       = 21;
  localparam int FULL_SCALE   = 10000;
  localparam int POINT_STEP   = FULL_SCALE / (POINTS - 1);
  localparam int HOLDOFF_LEN  = 40;
  localparam int DRAIN_LIMIT  = 20000;

  // Voltage at each point of the charge curve in mV, one row per table.
  localparam int CURVE_MV [4][POINTS] = '{
    '{ 3000, 3400, 3500, 3600, 3650, 3675, 3700, 3725, 3750, 3775, 3800,
       3825, 3850, 3875, 3900, 3950, 4000, 4050, 4100, 4150, 4200 },
    '{ 6000, 6800, 7000, 7200, 7300, 7350, 7400, 7450, 7500, 7550, 7600,
       7650, 7700, 7750, 7800, 7900, 8000, 8100, 8200, 8300, 8400 },
    '{ 9000, 10200, 10500, 10800, 10950, 11025, 11100, 11175, 11250, 11325,
       11400, 11475, 11550, 11625, 11700, 11850, 12000, 12150, 12300, 12450,
       12600 },
    '{ 12000, 13600, 14000, 14400, 14600, 14700, 14800, 14900, 15000, 15100,
       15200, 15300, 15400, 15500, 15800, 15800, 16000, 16200, 16400, 16600,
       16800 }
  };
  localparam int DEAD_MV  [5] = '{ 2500, 5000, 7500, 10000, 9000 };
  localparam int ERROR_MV [5] = '{ 3000, 6000, 9000, 12000, 11000 };

  typedef enum {
    STEP_SAMPLE,
    STEP_PACK,
    STEP_BACKPRESSURE,
    STEP_SETTLE
  } step_kind_t;

  typedef struct {
    step_kind_t  kind;
    int unsigned value;
    int unsigned gap;
  } plan_step_t;

  typedef struct {
    volt_t         volt;
    pct_t          pct;
    charge_state_t state;
  } charge_due_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  pack_t pack_type = bvcp_pkg::PACK_3S;
  logic  in_valid = 1'b0;
  logic  in_ready;
  volt_t voltage_mv = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  pct_t  percent_centi;
  logic [bvcp_pkg::STATE_W-1:0] charge_state;

  plan_step_t  sample_plan_q[$];
  charge_due_t charge_due_q[$];
  pack_t       pack_setting = bvcp_pkg::PACK_3S;
  logic        in_accepted = 1'b0;
  logic        cfg_accepted = 1'b0;
  logic        holdoff_req = 1'b0;
  int          mismatch_count = 0;

  battery_voltage_to_charge_percent uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .pack_type     (pack_type),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .voltage_mv    (voltage_mv),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .percent_centi (percent_centi),
    .charge_state  (charge_state)
  );

  always #1 clk = ~clk;

  // Charge predictor: thresholds first, then the first curve segment that
  // holds the voltage, interpolated with a rounded Q16 slope.
  function automatic void estimate_charge(input volt_t v_in, input pack_t pack,
                                          output pct_t pct, output charge_state_t st);
    int     sel;
    int     row;
    int     v;
    longint lo;
    longint hi;
    longint base;
    longint slope;
    longint sum;
    bit     found;
    sel   = (pack <= bvcp_pkg::PACK_UNKNOWN) ? int'(pack) : int'(bvcp_pkg::PACK_UNKNOWN);
    row   = (sel <= 3) ? sel : 2;
    v     = int'(v_in);
    pct   = '0;
    st    = bvcp_pkg::ST_OK;
    found = 1'b0;
    if (v < DEAD_MV[sel]) begin
      st = bvcp_pkg::ST_DEAD;
    end else if (v < ERROR_MV[sel]) begin
      st = bvcp_pkg::ST_ERROR;
    end else if (v >= CURVE_MV[row][POINTS-1]) begin
      pct = pct_t'(FULL_SCALE);
    end else begin
      for (int i = 0; i < POINTS - 1; i++) begin
        lo = CURVE_MV[row][i];
        hi = CURVE_MV[row][i+1];
        if (!found && v >= lo && v <= hi) begin
          found = 1'b1;
          base  = longint'(i) * POINT_STEP;
          if (hi <= lo) begin
            pct = pct_t'(base);
          end else begin
            slope = (longint'(POINT_STEP) * 65536 + (hi - lo) / 2) / (hi - lo);
            sum   = base + ((slope * (v - lo) + 32768) >> 16);
            pct   = pct_t'((sum > FULL_SCALE) ? FULL_SCALE : sum);
          end
        end
      end
    end
  endfunction

  // Idle cycles before a transaction: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  // Voltages weighted toward the curve, its points and the thresholds.
  function automatic int unsigned pick_voltage(input pack_t pack);
    int sel;
    int row;
    int r;
    int v;
    sel = (pack <= bvcp_pkg::PACK_UNKNOWN) ? int'(pack) : int'(bvcp_pkg::PACK_UNKNOWN);
    row = (sel <= 3) ? sel : 2;
    r   = $urandom_range(0, 99);
    if (r < 55) begin
      v = $urandom_range(ERROR_MV[sel], CURVE_MV[row][POINTS-1] + 50);
    end else if (r < 70) begin
      v = CURVE_MV[row][$urandom_range(0, POINTS - 1)] + $urandom_range(0, 4) - 2;
    end else if (r < 80) begin
      v = ($urandom_range(0, 1) ? DEAD_MV[sel] : ERROR_MV[sel]) + $urandom_range(0, 6) - 3;
    end else if (r < 90) begin
      v = $urandom_range(0, CURVE_MV[row][POINTS-1] + 500);
    end else begin
      v = $urandom_range(0, 32767);
    end
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  // Sender: offers the planned transactions; holds each until it is taken.
  always @(negedge clk) begin : drive_proc
    plan_step_t head;
    logic       nv_in;
    logic       nv_cfg;
    logic       nv_hold;
    nv_in   = 1'b0;
    nv_cfg  = 1'b0;
    nv_hold = 1'b0;
    if (rst) begin
      nv_in = 1'b0;
    end else if (in_valid && !in_accepted) begin
      nv_in = 1'b1;
    end else if (cfg_valid && !cfg_accepted) begin
      nv_cfg = 1'b1;
    end else if (sample_plan_q.size() > 0) begin
      head = sample_plan_q[0];
      case (head.kind)
        STEP_SAMPLE: begin
          if (head.gap > 0) begin
            head.gap--;
            sample_plan_q[0] = head;
          end else begin
            nv_in = 1'b1;
            voltage_mv <= volt_t'(head.value);
            void'(sample_plan_q.pop_front());
          end
        end
        STEP_PACK: begin
          // The pack type changes only once every result has come back.
          if (charge_due_q.size() == 0) begin
            nv_cfg = 1'b1;
            pack_type <= pack_t'(head.value);
            void'(sample_plan_q.pop_front());
          end
        end
        STEP_BACKPRESSURE: begin
          nv_hold = 1'b1;
          void'(sample_plan_q.pop_front());
        end
        default: begin
          if (charge_due_q.size() == 0) void'(sample_plan_q.pop_front());
        end
      endcase
    end
    in_valid    <= nv_in;
    cfg_valid   <= nv_cfg;
    holdoff_req <= nv_hold;
  end

  // Receiver: random stalls, calm stretches, and a long requested hold-off.
  always @(negedge clk) begin : ready_proc
    int unsigned rx_cycle;
    int unsigned stall_left;
    int unsigned holdoff_left;
    logic        nv_ready;
    rx_cycle++;
    nv_ready = 1'b0;
    if (holdoff_req) holdoff_left = HOLDOFF_LEN;
    if (rst) begin
      nv_ready = 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      nv_ready = 1'b1;
      if ((rx_cycle % 700) >= 150 && $urandom_range(0, 7) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(1, 3);
      end
    end
    out_ready <= nv_ready;
  end

  // Observer: takes configuration and input transactions into the predictor
  // and checks each result transaction against the oldest prediction.
  always @(posedge clk) begin : observe_proc
    charge_due_t due;
    logic        took_in;
    logic        took_cfg;
    took_in  = !rst && in_valid && in_ready;
    took_cfg = !rst && cfg_valid && cfg_ready;
    if (rst) begin
      pack_setting = bvcp_pkg::PACK_3S;
    end else begin
      if (out_valid && out_ready) begin
        if (charge_due_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result percent_centi=%0d charge_state=%0d",
                   $time, percent_centi, charge_state);
        end else begin
          due = charge_due_q.pop_front();
          if (percent_centi !== due.pct || charge_state !== due.state) begin
            mismatch_count++;
            $display("%0t: voltage %0d mV: expected %0d / state %0d, got %0d / state %0d",
                     $time, due.volt, due.pct, due.state, percent_centi, charge_state);
          end
        end
      end
      if (took_cfg) pack_setting = pack_type;
      if (took_in) begin
        due.volt = voltage_mv;
        estimate_charge(voltage_mv, pack_setting, due.pct, due.state);
        charge_due_q.push_back(due);
      end
    end
    in_accepted  <= took_in;
    cfg_accepted <= took_cfg;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus plan, reset, and end of run.
  initial begin : main_proc
    int unsigned directed_3s [12];
    int unsigned directed_4s [6];
    int unsigned directed_1s [4];
    int unsigned directed_unk [3];
    pack_t       phase_pack [10];
    int unsigned burst_left;
    int unsigned drain_cycles;
    plan_step_t  s;

    directed_3s  = '{ 0, 32767, 7499, 7500, 8999, 9000, 10200, 10201, 11024, 11025,
                      12599, 12600 };
    directed_4s  = '{ 15800, 15801, 16799, 16800, 9999, 10000 };
    directed_1s  = '{ 2499, 2500, 3000, 4200 };
    directed_unk = '{ 8999, 9000, 11000 };
    phase_pack   = '{ bvcp_pkg::PACK_3S, bvcp_pkg::PACK_1S, bvcp_pkg::PACK_2S,
                      bvcp_pkg::PACK_4S, bvcp_pkg::PACK_UNKNOWN, PACK_SPARE_7,
                      PACK_SPARE_5, PACK_SPARE_6, bvcp_pkg::PACK_1S, bvcp_pkg::PACK_4S };

    // Directed part: thresholds, curve ends and points under several pack types,
    // starting from the reset pack type.
    s.kind = STEP_SAMPLE;
    foreach (directed_3s[i]) begin
      s.value = directed_3s[i]; s.gap = pick_gap(); sample_plan_q.push_back(s);
    end
    s.kind = STEP_PACK; s.value = bvcp_pkg::PACK_4S; s.gap = 0; sample_plan_q.push_back(s);
    s.kind = STEP_SAMPLE;
    foreach (directed_4s[i]) begin
      s.value = directed_4s[i]; s.gap = pick_gap(); sample_plan_q.push_back(s);
    end
    s.kind = STEP_PACK; s.value = bvcp_pkg::PACK_1S; s.gap = 0; sample_plan_q.push_back(s);
    s.kind = STEP_SAMPLE;
    foreach (directed_1s[i]) begin
      s.value = directed_1s[i]; s.gap = pick_gap(); sample_plan_q.push_back(s);
    end
    s.kind = STEP_PACK; s.value = bvcp_pkg::PACK_UNKNOWN; s.gap = 0;
    sample_plan_q.push_back(s);
    s.kind = STEP_SAMPLE;
    foreach (directed_unk[i]) begin
      s.value = directed_unk[i]; s.gap = pick_gap(); sample_plan_q.push_back(s);
    end

    // Random part: one phase per pack setting. Every third phase runs without
    // idling; two phases force a long receiver hold-off under full input load,
    // and one pauses the sender until everything has drained.
    burst_left = 0;
    foreach (phase_pack[p]) begin
      s.kind = STEP_PACK; s.value = phase_pack[p]; s.gap = 0; sample_plan_q.push_back(s);
      for (int n = 0; n < 108; n++) begin
        if ((p == 2 || p == 6) && n == 30) begin
          s.kind = STEP_BACKPRESSURE; s.value = 0; s.gap = 0; sample_plan_q.push_back(s);
          burst_left = 20;
        end
        if (p == 5 && n == 50) begin
          s.kind = STEP_SETTLE; s.value = 0; s.gap = 0; sample_plan_q.push_back(s);
        end
        s.kind  = STEP_SAMPLE;
        s.value = pick_voltage(phase_pack[p]);
        s.gap   = (p % 3 == 2 || burst_left > 0) ? 0 : pick_gap();
        if (burst_left > 0) burst_left--;
        sample_plan_q.push_back(s);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (sample_plan_q.size() != 0 || in_valid || cfg_valid) @(posedge clk);
    drain_cycles = 0;
    while (charge_due_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (charge_due_q.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time, charge_due_q.size());
    end
    repeat (6) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/bvcp_pkg.sv
sv/bvcp_seg.sv
sv/bvcp_interp.sv
sv/battery_voltage_to_charge_percent.sv
verif/battery_voltage_to_charge_percent_test.sv
